// ----- src/dtf_pkg.sv -----
// shared types and constants for the degenerate triangle filter
// no dependencies; imported by the interfaces and by all modules but dtf_vstore

package dtf_pkg;

  localparam int CORNER_W  = 32;
  localparam int SLOT_W    = 12;
  localparam int THR_W     = 63;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 1;

  typedef enum logic {
    REQ_LOAD,
    REQ_FACE
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_THR,
    CFG_VERTEX_CNT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_KEEP,
    VERDICT_REPEAT,
    VERDICT_RANGE,
    VERDICT_FLAT
  } verdict_t;

  // face word as it travels down the pipeline
  typedef struct packed {
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
    verdict_t            verdict;
  } face_tag_t;

endpackage

// ----- src/dtf_in_if.sv -----
// input channel: vertex loads and face tests, valid/ready handshake
// depends on dtf_pkg

interface dtf_in_if import dtf_pkg::*; #(
  parameter int COORD_BITS = 16
) ();

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic        [SLOT_W-1:0]     vertex_slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic        [CORNER_W-1:0]   corner_a;
  logic        [CORNER_W-1:0]   corner_b;
  logic        [CORNER_W-1:0]   corner_c;

  modport source (
    output valid, req_type, vertex_slot, coord_x, coord_y, coord_z,
           corner_a, corner_b, corner_c,
    input  ready
  );

  modport sink (
    input  valid, req_type, vertex_slot, coord_x, coord_y, coord_z,
           corner_a, corner_b, corner_c,
    output ready
  );

endinterface

// ----- src/dtf_out_if.sv -----
// result channel: one verdict word per face, valid/ready handshake
// depends on dtf_pkg

interface dtf_out_if import dtf_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                keep;
  logic [1:0]          verdict;
  logic [CORNER_W-1:0] out_corner_a;
  logic [CORNER_W-1:0] out_corner_b;
  logic [CORNER_W-1:0] out_corner_c;

  modport source (
    output valid, keep, verdict, out_corner_a, out_corner_b, out_corner_c,
    input  ready
  );

  modport sink (
    input  valid, keep, verdict, out_corner_a, out_corner_b, out_corner_c,
    output ready
  );

endinterface

// ----- src/degenerate_triangle_filter.sv -----
// degenerate triangle filter: a face word passes the store read, five area stages and the
// output register before its verdict appears; one word per cycle while the output is not stalled.
// vertex loads write all three store copies (slots below VERTICES only) and give no word.
// rst_n (synchronous) clears the pipeline valids and both config registers;
// the vertex store is not cleared and holds unknown data until written.

module degenerate_triangle_filter import dtf_pkg::*; #(
  parameter int VERTICES   = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dtf_in_if.sink               in_w,
  dtf_out_if.source            out_w,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(VERTICES);
  localparam int DW = 3 * COORD_BITS;
  localparam logic [CORNER_W-1:0] VERT_LIM = CORNER_W'(VERTICES);

  // configuration
  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] vcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      vcnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AREA_THR:   thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_VERTEX_CNT: vcnt_r <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // input decode
  logic                in_fire;
  logic                is_face;
  logic [CORNER_W-1:0] slot_ext;
  logic                slot_ok;
  logic [CORNER_W-1:0] limit;
  logic                dup;
  logic                oor;
  verdict_t            pre_verdict;
  face_tag_t           in_tag;

  assign in_fire  = in_w.valid && in_w.ready;
  assign is_face  = in_w.req_type == REQ_FACE;
  assign slot_ext = CORNER_W'(in_w.vertex_slot);
  assign slot_ok  = slot_ext < VERT_LIM;
  assign limit    = (CORNER_W'(vcnt_r) < VERT_LIM) ? CORNER_W'(vcnt_r) : VERT_LIM;
  assign dup      = (in_w.corner_a == in_w.corner_b) || (in_w.corner_b == in_w.corner_c)
                 || (in_w.corner_a == in_w.corner_c);
  assign oor      = (in_w.corner_a >= limit) || (in_w.corner_b >= limit)
                 || (in_w.corner_c >= limit);

  always_comb begin
    priority if (dup) begin
      pre_verdict = VERDICT_REPEAT;
    end else if (oor) begin
      pre_verdict = VERDICT_RANGE;
    end else begin
      pre_verdict = VERDICT_KEEP;
    end
    in_tag = '{a: in_w.corner_a, b: in_w.corner_b, c: in_w.corner_c,
               verdict: pre_verdict};
  end

  // stage 1: store read, one copy per corner
  logic            s1_valid_r;
  face_tag_t       s1_tag_r;
  logic            en1;
  logic            ar_in_ready;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic [DW-1:0]   va;
  logic [DW-1:0]   vb;
  logic [DW-1:0]   vc;

  assign en1        = !s1_valid_r || ar_in_ready;
  assign in_w.ready = en1;
  assign mem_we     = in_fire && !is_face && slot_ok;
  assign mem_waddr  = slot_ext[AW-1:0];
  assign mem_wdata  = {in_w.coord_z, in_w.coord_y, in_w.coord_x};

  dtf_vstore #(.DEPTH(VERTICES), .AW(AW), .DW(DW)) u_vstore_a (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (en1),
    .raddr (in_w.corner_a[AW-1:0]),
    .rdata (va)
  );

  dtf_vstore #(.DEPTH(VERTICES), .AW(AW), .DW(DW)) u_vstore_b (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (en1),
    .raddr (in_w.corner_b[AW-1:0]),
    .rdata (vb)
  );

  dtf_vstore #(.DEPTH(VERTICES), .AW(AW), .DW(DW)) u_vstore_c (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (en1),
    .raddr (in_w.corner_c[AW-1:0]),
    .rdata (vc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_fire && is_face;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_tag_r <= in_tag;
    end
  end

  // area pipeline
  logic      ar_out_valid;
  logic      ar_out_ready;
  face_tag_t ar_out_tag;
  logic      ar_ok;

  dtf_area #(.CB(COORD_BITS)) u_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (ar_in_ready),
    .in_tag    (s1_tag_r),
    .in_va     (va),
    .in_vb     (vb),
    .in_vc     (vc),
    .thr       (thr_r),
    .out_valid (ar_out_valid),
    .out_ready (ar_out_ready),
    .out_tag   (ar_out_tag),
    .out_ok    (ar_ok)
  );

  // output register
  logic      out_valid_r;
  logic      out_keep_r;
  face_tag_t out_tag_r;
  face_tag_t fin_tag;

  assign ar_out_ready = !out_valid_r || out_w.ready;

  always_comb begin
    fin_tag = ar_out_tag;
    if (ar_out_tag.verdict == VERDICT_KEEP && !ar_ok) begin
      fin_tag.verdict = VERDICT_FLAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ar_out_ready) begin
      out_valid_r <= ar_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ar_out_ready) begin
      out_tag_r  <= fin_tag;
      out_keep_r <= fin_tag.verdict == VERDICT_KEEP;
    end
  end

  assign out_w.valid        = out_valid_r;
  assign out_w.keep         = out_keep_r;
  assign out_w.verdict      = out_tag_r.verdict;
  assign out_w.out_corner_a = out_tag_r.a;
  assign out_w.out_corner_b = out_tag_r.b;
  assign out_w.out_corner_c = out_tag_r.c;

`ifndef SYNTHESIS
  a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_w.req_type == REQ_LOAD |=> !s1_valid_r)
    else $error("vertex load entered the face pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !ar_in_ready |=> s1_valid_r && $stable(s1_tag_r))
    else $error("stalled face word lost in read stage");

  a_repeat_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.verdict == VERDICT_REPEAT |->
      out_tag_r.a == out_tag_r.b || out_tag_r.b == out_tag_r.c ||
      out_tag_r.a == out_tag_r.c)
    else $error("repeated-index verdict without equal corners");

  a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.verdict == VERDICT_RANGE |->
      out_tag_r.a >= limit || out_tag_r.b >= limit || out_tag_r.c >= limit)
    else $error("range verdict with all corners in range");
`endif

endmodule

// ----- src/dtf_vstore.sv -----
// one copy of the vertex store: one write port, one registered read port
// no package dependency; instantiated once per face corner

module dtf_vstore #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] store_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= store_r[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

// ----- src/dtf_area.sv -----
// area test pipeline: edges, cross product, squared length, threshold compare
// depends on dtf_pkg; five stages with per-stage valid and backpressure

module dtf_area import dtf_pkg::*; #(
  parameter int CB = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  face_tag_t        in_tag,
  input  logic [3*CB-1:0]  in_va,
  input  logic [3*CB-1:0]  in_vb,
  input  logic [3*CB-1:0]  in_vc,
  input  logic [THR_W-1:0] thr,
  output logic             out_valid,
  input  logic             out_ready,
  output face_tag_t        out_tag,
  output logic             out_ok
);

  localparam int EW  = CB + 1;       // edge component
  localparam int PW  = 2 * EW;       // edge product
  localparam int NW  = PW + 1;       // signed cross product component
  localparam int MW  = 2 * CB + 1;   // magnitude of a component
  localparam int LW  = CB + 1;       // low slice for squaring
  localparam int HW  = MW - LW;      // high slice for squaring
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int CW  = (SW > THR_W) ? SW : THR_W;
  localparam int NS  = 5;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  face_tag_t     tag_r [NS];

  // backpressure ripples from the output back to the input
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: edges and the edge products of the cross product
  logic signed [CB-1:0] crd_a [3];
  logic signed [CB-1:0] crd_b [3];
  logic signed [CB-1:0] crd_c [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] prod_nxt [6];
  logic signed [PW-1:0] prod_r [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_a[k] = in_va[k*CB +: CB];
      crd_b[k] = in_vb[k*CB +: CB];
      crd_c[k] = in_vc[k*CB +: CB];
      e1[k]    = EW'(crd_b[k]) - EW'(crd_a[k]);
      e2[k]    = EW'(crd_c[k]) - EW'(crd_a[k]);
    end
    prod_nxt[0] = PW'(e1[1]) * PW'(e2[2]);
    prod_nxt[1] = PW'(e1[2]) * PW'(e2[1]);
    prod_nxt[2] = PW'(e1[2]) * PW'(e2[0]);
    prod_nxt[3] = PW'(e1[0]) * PW'(e2[2]);
    prod_nxt[4] = PW'(e1[0]) * PW'(e2[1]);
    prod_nxt[5] = PW'(e1[1]) * PW'(e2[0]);
  end

  // stage 1: cross product components and their magnitudes
  logic signed [NW-1:0] nd [3];
  logic        [NW-1:0] na [3];
  logic        [MW-1:0] mag_nxt [3];
  logic        [MW-1:0] mag_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nd[k]      = NW'(prod_r[2*k]) - NW'(prod_r[2*k+1]);
      na[k]      = nd[k][NW-1] ? NW'(-nd[k]) : NW'(nd[k]);
      mag_nxt[k] = na[k][MW-1:0];
    end
  end

  // stage 2: partial products of each square
  logic [2*HW-1:0]  hh_nxt [3];
  logic [HW+LW-1:0] hl_nxt [3];
  logic [2*LW-1:0]  ll_nxt [3];
  logic [2*HW-1:0]  hh_r [3];
  logic [HW+LW-1:0] hl_r [3];
  logic [2*LW-1:0]  ll_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = mag_r[k][MW-1:LW] * mag_r[k][MW-1:LW];
      hl_nxt[k] = mag_r[k][MW-1:LW] * mag_r[k][LW-1:0];
      ll_nxt[k] = mag_r[k][LW-1:0] * mag_r[k][LW-1:0];
    end
  end

  // stage 3: squares assembled; cross term counts twice
  logic [SQW-1:0] sq_nxt [3];
  logic [SQW-1:0] sq_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = (SQW'(hh_r[k]) << (2 * LW)) + (SQW'(hl_r[k]) << (LW + 1))
                + SQW'(ll_r[k]);
    end
  end

  // stage 4: squared normal length
  logic [SW-1:0] sum_nxt;
  logic [SW-1:0] sum_r;

  assign sum_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r   <= prod_nxt;
      tag_r[0] <= in_tag;
    end
    if (en[1]) begin
      mag_r    <= mag_nxt;
      tag_r[1] <= tag_r[0];
    end
    if (en[2]) begin
      hh_r     <= hh_nxt;
      hl_r     <= hl_nxt;
      ll_r     <= ll_nxt;
      tag_r[2] <= tag_r[1];
    end
    if (en[3]) begin
      sq_r     <= sq_nxt;
      tag_r[3] <= tag_r[2];
    end
    if (en[4]) begin
      sum_r    <= sum_nxt;
      tag_r[4] <= tag_r[3];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];
  assign out_ok    = CW'(sum_r) > CW'(thr);

endmodule

// ----- dv/tb_top.sv -----
// testbench for degenerate_triangle_filter: vertex loads and face tests in, verdicts out
// depends on dtf_pkg, dtf_in_if and dtf_out_if; checks each verdict against a typed expectation
// or an internal predictor of the vertex store and both config registers

module tb_top import dtf_pkg::*; ();

  localparam int COORD_W       = 16;
  localparam int VERT_N        = 4096;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_WORDS   = 140;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_CAP     = 100;

  typedef enum {ROW_CFG, ROW_WORD} row_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    req_t                      kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CORNER_W-1:0]       a;
    logic [CORNER_W-1:0]       b;
    logic [CORNER_W-1:0]       c;
  } in_word_t;

  typedef struct {
    logic                keep;
    verdict_t            verdict;
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
  } verdict_word_t;

  typedef struct {
    row_kind_t        kind;
    logic [THR_W-1:0] thr;
    logic [CNT_W-1:0] cnt;
    in_word_t         w;
    bit               typed;
    verdict_t         typed_v;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  dtf_in_if #(.COORD_BITS(COORD_W)) in_w ();
  dtf_out_if                        out_w ();

  degenerate_triangle_filter #(.VERTICES(VERT_N), .COORD_BITS(COORD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_w      (in_w),
    .out_w     (out_w),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint           vtx [VERT_N][3];
  bit               vtx_written [VERT_N];
  int               written_slots[$];
  logic [THR_W-1:0] thr_m;
  logic [CNT_W-1:0] cnt_m;

  verdict_word_t verdicts_q[$];
  stim_row_t     dir_rows[$];
  int            err_count     = 0;
  int            quiet_cycles  = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left     = 0;

  function automatic logic [CORNER_W:0] corner_limit();
    return (cnt_m < VERT_N) ? (CORNER_W+1)'(cnt_m) : (CORNER_W+1)'(VERT_N);
  endfunction

  function automatic bit area_passes(logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b,
                                     logic [CORNER_W-1:0] c);
    longint       e1[3];
    longint       e2[3];
    longint       n[3];
    logic [63:0]  mg;
    logic [127:0] sq_sum;
    sq_sum = '0;
    for (int k = 0; k < 3; k++) begin
      e1[k] = vtx[b[SLOT_W-1:0]][k] - vtx[a[SLOT_W-1:0]][k];
      e2[k] = vtx[c[SLOT_W-1:0]][k] - vtx[a[SLOT_W-1:0]][k];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    // squared normal can pass 64 bits with full-scale coordinates
    for (int k = 0; k < 3; k++) begin
      mg = (n[k] < 0) ? -n[k] : n[k];
      sq_sum += {64'd0, mg} * {64'd0, mg};
    end
    return sq_sum > {65'd0, thr_m};
  endfunction

  function automatic verdict_word_t judge_face(in_word_t w);
    verdict_word_t      r;
    logic [CORNER_W:0]  lim;
    lim = corner_limit();
    r.a = w.a;
    r.b = w.b;
    r.c = w.c;
    if (w.a == w.b || w.b == w.c || w.a == w.c) r.verdict = VERDICT_REPEAT;
    else if (w.a >= lim || w.b >= lim || w.c >= lim) r.verdict = VERDICT_RANGE;
    else if (!area_passes(w.a, w.b, w.c)) r.verdict = VERDICT_FLAT;
    else r.verdict = VERDICT_KEEP;
    r.keep = (r.verdict == VERDICT_KEEP);
    return r;
  endfunction

  function automatic void apply_word(in_word_t w, bit typed, verdict_t typed_v);
    verdict_word_t r;
    if (w.kind == REQ_LOAD) begin
      vtx[w.slot][0] = w.x;
      vtx[w.slot][1] = w.y;
      vtx[w.slot][2] = w.z;
      if (!vtx_written[w.slot]) begin
        vtx_written[w.slot] = 1'b1;
        written_slots = {written_slots, int'(w.slot)};
      end
    end else begin
      if (typed) begin
        r.a       = w.a;
        r.b       = w.b;
        r.c       = w.c;
        r.verdict = typed_v;
        r.keep    = (typed_v == VERDICT_KEEP);
      end else begin
        r = judge_face(w);
      end
      verdicts_q = {verdicts_q, r};
    end
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  function automatic stim_row_t cfg_row(logic [THR_W-1:0] thr, logic [CNT_W-1:0] cnt);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.thr   = thr;
    r.cnt   = cnt;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t load_row(logic [SLOT_W-1:0] slot, logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] z);
    stim_row_t r;
    r.kind   = ROW_WORD;
    r.w.kind = REQ_LOAD;
    r.w.slot = slot;
    r.w.x    = x;
    r.w.y    = y;
    r.w.z    = z;
    r.w.a    = '0;
    r.w.b    = '0;
    r.w.c    = '0;
    r.typed  = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t face_row(logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b,
                                         logic [CORNER_W-1:0] c, bit typed, verdict_t v);
    stim_row_t r;
    r.kind    = ROW_WORD;
    r.w.kind  = REQ_FACE;
    r.w.slot  = '0;
    r.w.x     = '0;
    r.w.y     = '0;
    r.w.z     = '0;
    r.w.a     = a;
    r.w.b     = b;
    r.w.c     = c;
    r.typed   = typed;
    r.typed_v = v;
    return r;
  endfunction

  function automatic logic [CORNER_W-1:0] pick_written();
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  function automatic in_word_t make_random_word();
    in_word_t          w;
    logic [SLOT_W-1:0] src;
    logic [CORNER_W:0] lim;
    int                mode;
    int                pos;
    logic [CORNER_W-1:0] bad;
    w.slot = SLOT_W'($urandom);
    w.x    = COORD_W'($urandom);
    w.y    = COORD_W'($urandom);
    w.z    = COORD_W'($urandom);
    w.a    = $urandom;
    w.b    = $urandom;
    w.c    = $urandom;
    lim    = corner_limit();
    if ($urandom_range(0, 99) < 35) begin
      w.kind = REQ_LOAD;
      if ($urandom_range(0, 99) < 70) w.slot = SLOT_W'($urandom_range(0, 63));
      mode = $urandom_range(0, 3);
      if (mode == 1) begin
        w.x = COORD_W'($urandom_range(0, 16) - 8);
        w.y = COORD_W'($urandom_range(0, 16) - 8);
        w.z = COORD_W'($urandom_range(0, 16) - 8);
      end else if (mode == 2) begin
        // duplicate of a stored vertex gives zero-area faces
        src = SLOT_W'(pick_written());
        w.x = COORD_W'(vtx[src][0]);
        w.y = COORD_W'(vtx[src][1]);
        w.z = COORD_W'(vtx[src][2]);
      end else if (mode == 3) begin
        w.x = COORD_W'(($urandom_range(0, 1) != 0) ? -32768 : 32767);
        w.y = COORD_W'(($urandom_range(0, 1) != 0) ? -1 : 0);
        w.z = COORD_W'(($urandom_range(0, 1) != 0) ? -32768 : 32767);
      end
      return w;
    end
    w.kind = REQ_FACE;
    mode   = $urandom_range(0, 99);
    if (mode < 90) begin
      w.a = pick_written();
      do w.b = pick_written(); while (w.b == w.a);
      do w.c = pick_written(); while (w.c == w.a || w.c == w.b);
    end
    if (mode >= 65 && mode < 75) begin
      pos = $urandom_range(0, 2);
      if (pos == 0) w.b = w.a;
      else if (pos == 1) w.c = w.b;
      else w.a = w.c;
    end else if (mode >= 75 && mode < 90) begin
      bad = ($urandom_range(0, 1) != 0) ? lim[CORNER_W-1:0] + $urandom_range(0, 2)
                                        : CORNER_W'($urandom);
      pos = $urandom_range(0, 2);
      if (pos == 0) w.a = bad;
      else if (pos == 1) w.b = bad;
      else w.c = bad;
    end
    // never let a face reach the area test on a slot that holds no vertex yet
    if (w.a != w.b && w.b != w.c && w.a != w.c && w.a < lim && w.b < lim && w.c < lim &&
        !(vtx_written[w.a[SLOT_W-1:0]] && vtx_written[w.b[SLOT_W-1:0]] &&
          vtx_written[w.c[SLOT_W-1:0]]))
      w.c = w.a;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < PRINT_CAP)
      $display("mismatch %s: got 'h%0h, expected 'h%0h", what, got, want);
    err_count++;
  endtask

  task automatic push_word(input in_word_t w, input bit typed, input verdict_t typed_v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_w.valid <= 1'b0;
      @(negedge clk);
    end
    in_w.req_type    <= w.kind;
    in_w.vertex_slot <= w.slot;
    in_w.coord_x     <= w.x;
    in_w.coord_y     <= w.y;
    in_w.coord_z     <= w.z;
    in_w.corner_a    <= w.a;
    in_w.corner_b    <= w.b;
    in_w.corner_c    <= w.c;
    in_w.valid       <= 1'b1;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    apply_word(w, typed, typed_v);
    @(negedge clk);
  endtask

  // stop offering words and wait until every verdict is back and loads have settled
  task automatic drain();
    in_w.valid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [CNT_W-1:0] cnt);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_AREA_THR;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    thr_m = thr;
    @(negedge clk);
    cfg_idx   <= CFG_VERTEX_CNT;
    cfg_wdata <= CFG_W'(cnt);
    @(posedge clk);
    cnt_m = cnt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_w.ready <= 1'b0;
        hold_left--;
      end else begin
        out_w.ready <= !($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    verdict_word_t want;
    if (rst_n && out_w.valid && out_w.ready) begin
      if (verdicts_q.size() == 0) begin
        report_mismatch("unexpected word, corner_a", out_w.out_corner_a, '0);
      end else begin
        want = verdicts_q.pop_front();
        if (out_w.keep !== want.keep) report_mismatch("keep", out_w.keep, want.keep);
        if (out_w.verdict !== want.verdict)
          report_mismatch("verdict", out_w.verdict, want.verdict);
        if (out_w.out_corner_a !== want.a)
          report_mismatch("out_corner_a", out_w.out_corner_a, want.a);
        if (out_w.out_corner_b !== want.b)
          report_mismatch("out_corner_b", out_w.out_corner_b, want.b);
        if (out_w.out_corner_c !== want.c)
          report_mismatch("out_corner_c", out_w.out_corner_c, want.c);
      end
    end
    if (rst_n && ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [THR_W-1:0] thr;
    logic [CNT_W-1:0] cnt;
    idle_mode_t       mode;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_AREA_THR;
    cfg_wdata        = '0;
    in_w.valid       = 1'b0;
    in_w.req_type    = 1'b0;
    in_w.vertex_slot = '0;
    in_w.coord_x     = '0;
    in_w.coord_y     = '0;
    in_w.coord_z     = '0;
    in_w.corner_a    = '0;
    in_w.corner_b    = '0;
    in_w.corner_c    = '0;
    thr_m            = '0;
    cnt_m            = '0;
    foreach (vtx_written[i]) vtx_written[i] = 1'b0;

    // nothing in range until the count is raised
    add_row(cfg_row('0, '0));
    add_row(face_row(0, 0, 0, 1'b1, VERDICT_REPEAT));
    add_row(face_row(5, 6, 5, 1'b1, VERDICT_REPEAT));
    add_row(face_row(7, 9, 9, 1'b1, VERDICT_REPEAT));
    add_row(face_row(0, 1, 2, 1'b1, VERDICT_RANGE));
    add_row(face_row('1, 32'hFFFF_FFFE, 0, 1'b1, VERDICT_RANGE));
    add_row(cfg_row('0, 4096));
    add_row(load_row(0, 0, 0, 0));
    add_row(load_row(1, 1, 0, 0));
    add_row(load_row(2, 0, 1, 0));
    add_row(load_row(5, 2, 0, 0));
    add_row(load_row(3, 32767, 32767, 32767));
    add_row(load_row(4, -32768, 32767, -32768));
    add_row(load_row(4095, -32768, -32768, -32768));
    // unit right triangle has squared normal of one
    add_row(face_row(0, 1, 2, 1'b1, VERDICT_KEEP));
    add_row(face_row(0, 1, 5, 1'b1, VERDICT_FLAT));
    add_row(face_row(3, 4095, 4, 1'b0, VERDICT_KEEP));
    add_row(face_row(0, 1, 4096, 1'b1, VERDICT_RANGE));
    add_row(face_row(4095, 0, 1, 1'b0, VERDICT_KEEP));
    // threshold equal to the squared normal drops the face
    add_row(cfg_row(1, 4096));
    add_row(face_row(0, 1, 2, 1'b1, VERDICT_FLAT));
    // full-scale face overflows 64 bits and beats the largest threshold
    add_row(cfg_row('1, 8191));
    add_row(face_row(3, 4095, 4, 1'b0, VERDICT_KEEP));
    add_row(face_row(0, 2, 4096, 1'b1, VERDICT_RANGE));
    add_row(face_row(0, 1, 2, 1'b1, VERDICT_FLAT));
    add_row(cfg_row('0, 3));
    add_row(face_row(2, 1, 0, 1'b1, VERDICT_KEEP));
    add_row(face_row(0, 1, 3, 1'b1, VERDICT_RANGE));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        set_config(dir_rows[i].thr, dir_rows[i].cnt);
      end else begin
        push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].typed_v);
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin thr = '0;                           cnt = 4096; end
        1: begin thr = THR_W'($urandom_range(0, 4096)); cnt = 64; end
        2: begin thr = '1;                           cnt = 8191; end
        3: begin
          thr = THR_W'({$urandom, $urandom});
          cnt = CNT_W'($urandom_range(0, 8191));
        end
        4: begin thr = {31'd0, $urandom} << $urandom_range(0, 31); cnt = 4096; end
        5: begin thr = THR_W'($urandom_range(0, 64)); cnt = 4095; end
        6: begin thr = '0;                           cnt = CNT_W'($urandom_range(2, 70)); end
        default: begin
          thr = THR_W'({$urandom, $urandom}) >> $urandom_range(0, 62);
          cnt = 8191;
        end
      endcase
      set_config(thr, cnt);
      mode          = idle_mode_t'(p % 4);
      send_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 9 : 0;
      recv_idle_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 9 : 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // long receiver hold-off while words keep coming, so the pipe backs up
        if (p == 0 && i == 20) hold_left = HOLD_CYCLES;
        if (p == 5 && i == PHASE_WORDS / 2) drain();
        push_word(make_random_word(), 1'b0, VERDICT_KEEP);
      end
    end

    drain();
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dtf_pkg.sv
src/dtf_in_if.sv
src/dtf_out_if.sv
src/dtf_vstore.sv
src/dtf_area.sv
src/degenerate_triangle_filter.sv
dv/tb_top.sv
